### hw/rtl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg : complex FIR energy shared definitions
// Widths, wavelet coefficient tables and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 7;
   localparam int ENERGY_W  = 32;
   localparam int ROM_DEPTH = 64;
   localparam int ROM_IDX_W = 6;
   localparam int ACC_W     = SAMPLE_W + COEF_W + ROM_IDX_W;
   localparam int SQ_W      = 2 * ACC_W;
   localparam int SUM_W     = SQ_W + 1;

   localparam logic signed [COEF_W-1:0] COEF_RE_ROM [ROM_DEPTH] = '{
      -7'sd4,  -7'sd2,  7'sd1,   7'sd5,   7'sd9,   7'sd12,  7'sd14,  7'sd13,
      7'sd9,   7'sd2,   -7'sd7,  -7'sd17, -7'sd24, -7'sd28, -7'sd27, -7'sd20,
      -7'sd9,  7'sd5,   7'sd19,  7'sd30,  7'sd36,  7'sd35,  7'sd28,  7'sd16,
      7'sd2,   -7'sd12, -7'sd22, -7'sd28, -7'sd28, -7'sd23, -7'sd15, -7'sd5,
      7'sd3,   7'sd10,  7'sd13,  7'sd14,  7'sd12,  7'sd8,   7'sd4,   7'sd0,
      -7'sd2,  -7'sd4,  -7'sd4,  -7'sd4,  -7'sd3,  -7'sd1,  7'sd0,   7'sd0,
      7'sd1,   7'sd1,   7'sd1,   7'sd1,   7'sd0,   7'sd0,   7'sd0,   7'sd0,
      7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0
   };

   localparam logic signed [COEF_W-1:0] COEF_IM_ROM [ROM_DEPTH] = '{
      -7'sd4,  -7'sd6,  -7'sd8,  -7'sd8,  -7'sd6,  -7'sd2,  7'sd3,   7'sd10,
      7'sd16,  7'sd20,  7'sd21,  7'sd18,  7'sd10,  -7'sd1,  -7'sd13, -7'sd24,
      -7'sd32, -7'sd34, -7'sd30, -7'sd20, -7'sd6,  7'sd9,   7'sd22,  7'sd31,
      7'sd34,  7'sd31,  7'sd22,  7'sd11,  -7'sd2,  -7'sd12, -7'sd19, -7'sd21,
      -7'sd19, -7'sd15, -7'sd8,  -7'sd2,  7'sd3,   7'sd7,   7'sd8,   7'sd8,
      7'sd6,   7'sd4,   7'sd1,   7'sd0,   -7'sd1,  -7'sd2,  -7'sd2,  -7'sd1,
      -7'sd1,  7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,
      7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0,   7'sd0
   };

   typedef struct packed {
      logic start;
      logic read;
      logic mac;
      logic square;
      logic load;
   } cfe_cmd_type;

   typedef struct packed {
      logic last_tap;
   } cfe_status_type;

endpackage

### hw/rtl/cfe_ram.sv
// ----------------------------------------------------------------------------
// cfe_ram : generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cfe_ctrl.sv
// ----------------------------------------------------------------------------
// cfe_ctrl : complex FIR energy controller
// Sequences ring write, tap walk, squaring and result hand-off.
// ----------------------------------------------------------------------------
module cfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cfe_pkg::cfe_cmd_type    cmd,
   input  cfe_pkg::cfe_status_type status
);
   import cfe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SQUARE,
      ST_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      mac_ff, mac_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;

   assign load = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      mac_in       = (state_ff == ST_READ);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mac_ff       <= mac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.start  = req_valid && (state_ff == ST_IDLE);
   assign cmd.read   = (state_ff == ST_READ);
   assign cmd.mac    = mac_ff;
   assign cmd.square = (state_ff == ST_SQUARE);
   assign cmd.load   = load;

endmodule

### hw/rtl/cfe_dp.sv
// ----------------------------------------------------------------------------
// cfe_dp : complex FIR energy datapath
// Sample ring, complex multiply-accumulate, squaring and output register.
// ----------------------------------------------------------------------------
module cfe_dp #(
   parameter int TAPS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cfe_pkg::cfe_cmd_type                cmd,
   output cfe_pkg::cfe_status_type             status,
   input  logic signed [cfe_pkg::SAMPLE_W-1:0] req_sample,
   output logic signed [cfe_pkg::ENERGY_W-1:0] rsp_energy,
   output logic                                rsp_overflow
);
   import cfe_pkg::*;

   localparam int PTR_W   = $clog2(TAPS);
   localparam int NUM_MAC = (TAPS < ROM_DEPTH) ? TAPS : ROM_DEPTH;
   localparam int TAP_W   = $clog2(NUM_MAC);

   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic [TAPS-1:0]   valid_ff;
   logic [PTR_W-1:0]  rd_addr_ff;
   logic [TAP_W-1:0]  tap_ff;
   logic [TAP_W-1:0]  tap_d_ff;
   logic              rd_valid_ff;
   logic [SAMPLE_W-1:0] rd_data;

   logic signed [SAMPLE_W-1:0]        x;
   logic signed [COEF_W-1:0]          coef_re, coef_im;
   logic signed [SAMPLE_W+COEF_W-1:0] prod_re, prod_im;
   logic signed [ACC_W-1:0]           acc_re_ff, acc_im_ff;
   logic signed [SQ_W-1:0]            sq_re_ff, sq_im_ff;
   logic [SUM_W-1:0]                  sum;
   logic signed [ENERGY_W-1:0]        energy_ff;
   logic                              overflow_ff;

   assign pos_in = (pos_ff == PTR_W'(TAPS - 1)) ? '0 : pos_ff + 1'b1;

   cfe_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TAPS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.start),
      .wr_addr (pos_in),
      .wr_data (req_sample),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= '0;
      end else if (cmd.start) begin
         pos_ff           <= pos_in;
         valid_ff[pos_in] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_addr_ff <= pos_in;
         tap_ff     <= '0;
      end else if (cmd.read) begin
         rd_addr_ff <= (rd_addr_ff == '0) ? PTR_W'(TAPS - 1) : rd_addr_ff - 1'b1;
         tap_ff     <= tap_ff + 1'b1;
      end
      if (cmd.read) begin
         rd_valid_ff <= valid_ff[rd_addr_ff];
         tap_d_ff    <= tap_ff;
      end
   end

   assign status.last_tap = (tap_ff == TAP_W'(NUM_MAC - 1));

   assign x       = rd_valid_ff ? $signed(rd_data) : '0;
   assign coef_re = COEF_RE_ROM[ROM_IDX_W'(tap_d_ff)];
   assign coef_im = COEF_IM_ROM[ROM_IDX_W'(tap_d_ff)];
   assign prod_re = x * coef_re;
   assign prod_im = x * coef_im;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (cmd.mac) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im);
      end
      if (cmd.square) begin
         sq_re_ff <= acc_re_ff * acc_re_ff;
         sq_im_ff <= acc_im_ff * acc_im_ff;
      end
      if (cmd.load) begin
         energy_ff   <= $signed(sum[ENERGY_W-1:0]);
         overflow_ff <= |sum[SUM_W-1:ENERGY_W-1];
      end
   end

   assign sum = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

   assign rsp_energy   = energy_ff;
   assign rsp_overflow = overflow_ff;

endmodule

### hw/rtl/complex_fir_energy_unit.sv
// ----------------------------------------------------------------------------
// complex_fir_energy_unit : complex wavelet FIR with squared magnitude
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_sample
//   rsp      out  rsp_valid/rsp_ready    rsp_energy, rsp_overflow
//
// Each request walks min(TAPS,64) taps of the ring on the single
// real/imaginary multiplier pair, one tap a cycle.
// A new request is taken while the previous result still waits in the
// output register; the result stage holds until that register is free.
// Reset clears the ring through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module complex_fir_energy_unit #(
   parameter int TAPS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cfe_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cfe_pkg::ENERGY_W-1:0] rsp_energy,
   output logic                                rsp_overflow
);
   import cfe_pkg::*;

   cfe_cmd_type    cmd;
   cfe_status_type status;

   cfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   cfe_dp #(
      .TAPS (TAPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .rsp_energy   (rsp_energy),
      .rsp_overflow (rsp_overflow)
   );

endmodule

### hw/rtl/cfe_checker.sv
// ----------------------------------------------------------------------------
// cfe_checker : port-level checks for complex_fir_energy_unit
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module cfe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [cfe_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cfe_pkg::ENERGY_W-1:0] rsp_energy,
   input logic                                rsp_overflow
);
   import cfe_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample))
      else $error("waiting request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_energy)
         && $stable(rsp_overflow))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("request taken or result shown too early");

   a_wrap_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_energy[ENERGY_W-1] |-> rsp_overflow)
      else $error("energy wrapped without overflow");

endmodule

bind complex_fir_energy_unit cfe_checker u_cfe_checker (.*);

### sim/complex_fir_energy_unit_tb.sv
// ----------------------------------------------------------------------------
// complex_fir_energy_unit_tb : self-checking bench for the complex FIR energy unit
// Drives signed samples through the request channel, directed first and then in random bursts, while
// the response side stalls on its own pattern. Every accepted sample updates
// a local copy of the sample ring, and the bench works out the expected
// squared magnitude and overflow flag from it. Responses are checked in order.
// ----------------------------------------------------------------------------
module complex_fir_energy_unit_tb;
   import cfe_pkg::*;

   localparam int TAPS            = 64;
   localparam int RANDOM_SAMPLES  = 480;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int IDLE_LIMIT      = 4000;
   localparam int PRINT_LIMIT     = 100;

   typedef enum int {
      FULL_RANGE, SMALL_RANGE, MID_RANGE, CONSTANT_RUN, ALTERNATING
   } flavour_type;
   typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, WINDOWED} stall_mode_type;

   typedef struct {
      logic signed [ENERGY_W-1:0] energy;
      logic                       overflow;
   } energy_result_type;

   class energy_scoreboard;
      logic signed [SAMPLE_W-1:0] ring [TAPS];
      int unsigned                newest_pos;
      energy_result_type          expected_energy_q [$];
      int unsigned                mismatches;

      function new();
         foreach (ring[i]) ring[i] = '0;
         newest_pos = 0;
         mismatches = 0;
      endfunction

      function energy_result_type filter_energy(logic signed [SAMPLE_W-1:0] sample);
         energy_result_type res;
         longint            acc_re;
         longint            acc_im;
         longint            total;
         int unsigned       idx;
         newest_pos = (newest_pos == TAPS - 1) ? 0 : newest_pos + 1;
         ring[newest_pos] = sample;
         acc_re = 0;
         acc_im = 0;
         idx    = newest_pos;
         for (int k = 0; k < TAPS; k++) begin
            if (k < ROM_DEPTH) begin
               acc_re += longint'(COEF_RE_ROM[k]) * longint'(ring[idx]);
               acc_im += longint'(COEF_IM_ROM[k]) * longint'(ring[idx]);
            end
            idx = (idx == 0) ? TAPS - 1 : idx - 1;
         end
         total        = acc_re * acc_re + acc_im * acc_im;
         res.energy   = total[ENERGY_W-1:0];
         res.overflow = (total > 64'sd2147483647);
         return res;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         expected_energy_q.push_back(filter_energy(sample));
      endfunction

      function int unsigned pending();
         return expected_energy_q.size();
      endfunction

      task report_mismatch(string what);
         if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_energy(logic signed [ENERGY_W-1:0] energy, logic overflow);
         energy_result_type want;
         if (expected_energy_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response energy=%0d overflow=%0b",
                                      energy, overflow));
            return;
         end
         want = expected_energy_q.pop_front();
         if (energy !== want.energy)
            report_mismatch($sformatf("energy %0d, want %0d", energy, want.energy));
         if (overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, want %0b", overflow, want.overflow));
      endtask

      task check_drained();
         if (expected_energy_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_energy_q.size()));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [ENERGY_W-1:0]  rsp_energy;
   logic                        rsp_overflow;

   energy_scoreboard sb = new();
   bit               hold_off_req = 1'b0;
   int unsigned      idle_cycles = 0;

   complex_fir_energy_unit #(
      .TAPS(TAPS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_energy  (rsp_energy),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_sample);
         if (rsp_valid && rsp_ready) sb.check_energy(rsp_energy, rsp_overflow);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: own stall pattern, with one long hold-off on demand
   initial begin
      int unsigned    cyc;
      stall_mode_type mode;
      cyc       = 0;
      mode      = ALWAYS_READY;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (cyc % 64 == 0) mode = stall_mode_type'($urandom_range(0, 3));
            case (mode)
               ALWAYS_READY:   rsp_ready <= 1'b1;
               COIN_FLIP:      rsp_ready <= ($urandom_range(0, 1) != 0);
               MOSTLY_STALLED: rsp_ready <= ($urandom_range(0, 5) == 0);
               default:        rsp_ready <= ((cyc % 40) < 4);
            endcase
            cyc++;
         end
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(flavour_type flavour, int n,
                                                             logic [SAMPLE_W-1:0] run_value);
      case (flavour)
         FULL_RANGE:   return SAMPLE_W'($urandom);
         SMALL_RANGE:  return SAMPLE_W'(int'($urandom_range(0, 30)) - 15);
         MID_RANGE:    return SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
         CONSTANT_RUN: return run_value;
         default:      return n[0] ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   initial begin
      logic signed [SAMPLE_W-1:0] directed [] = '{
         16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA,
         16'sd0, 16'sd0, 16'sd2, -16'sd2, 16'sd100, -16'sd100,
         16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
         16'sd3, -16'sd7, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0
      };
      int unsigned sent;
      int unsigned burst;
      flavour_type flavour;
      logic [SAMPLE_W-1:0] run_value;
      bit          squeezed;
      bit          drained_mid;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      sent        = 0;
      squeezed    = 1'b0;
      drained_mid = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_sample(directed[i]);
      wait_drained();

      while (sent < RANDOM_SAMPLES) begin
         burst     = $urandom_range(1, 12);
         flavour   = flavour_type'($urandom_range(0, 4));
         run_value = SAMPLE_W'($urandom);
         if (sent >= 160 && !squeezed) begin
            // fill the unit while responses are held back
            hold_off_req = 1'b1;
            squeezed     = 1'b1;
            burst        = 8;
         end
         if (sent >= 320 && !drained_mid) begin
            wait_drained();
            drained_mid = 1'b1;
         end
         for (int i = 0; i < burst && sent < RANDOM_SAMPLES; i++) begin
            send_sample(pick_sample(flavour, i, run_value));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 150));
      end

      wait_drained();
      repeat (100) @(posedge clock);
      sb.check_drained();
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_ram.sv
hw/rtl/cfe_ctrl.sv
hw/rtl/cfe_dp.sv
hw/rtl/complex_fir_energy_unit.sv
hw/rtl/cfe_checker.sv
sim/complex_fir_energy_unit_tb.sv
